// ===== rtl/core/process_id_table_engine_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Process-id table engine assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef PROCESS_ID_TABLE_ENGINE_UNIT_ASSERT_SVH
`define PROCESS_ID_TABLE_ENGINE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PIT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PIT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PIT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/pit_pkg.sv =====
// ---------------------------------------------------------------------------
// pit_pkg
// Request and response types, command and result codes of the pid table.
// ---------------------------------------------------------------------------
package pit_pkg;

    localparam int PORT_PID_W = 15;

    localparam logic [2:0] CMD_ALLOC  = 3'd0;
    localparam logic [2:0] CMD_UNALOC = 3'd1;
    localparam logic [2:0] CMD_DETACH = 3'd2;
    localparam logic [2:0] CMD_EXIT   = 3'd3;
    localparam logic [2:0] CMD_JOIN   = 3'd4;
    localparam logic [2:0] CMD_QUERY  = 3'd5;

    localparam logic [2:0] RC_OK       = 3'd0;
    localparam logic [2:0] RC_INVALID  = 3'd1;
    localparam logic [2:0] RC_NOPID    = 3'd2;
    localparam logic [2:0] RC_DEADLOCK = 3'd3;
    localparam logic [2:0] RC_FULL     = 3'd4;
    localparam logic [2:0] RC_WAIT     = 3'd5;

    localparam logic [31:0] BOOT_STATUS = 32'h0000_baad;

    typedef struct packed {
        logic [2:0]            command;
        logic [PORT_PID_W-1:0] subject_pid;
        logic [PORT_PID_W-1:0] caller_pid;
        logic signed [31:0]    exit_code;
        logic                  detach_children;
        logic                  no_hang;
    } pit_req_t;

    typedef struct packed {
        logic [2:0]            result_code;
        logic [PORT_PID_W-1:0] result_pid;
        logic signed [31:0]    exit_status_out;
        logic                  parent_match;
    } pit_rsp_t;

    typedef struct packed {
        logic detached;
        logic exited;
        logic valid;
    } pit_flags_t;

endpackage

// ===== rtl/core/pit_stream_if.sv =====
// ---------------------------------------------------------------------------
// pit_stream_if
// Valid/ready channel carrying one payload struct per request.
// ---------------------------------------------------------------------------
interface pit_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/pit_mod_unit.sv =====
// ---------------------------------------------------------------------------
// pit_mod_unit
// Pid-to-slot reduction by reciprocal multiplication: register the value, then the quotient, then the remainder.
// ---------------------------------------------------------------------------
module pit_mod_unit #(
    parameter int SLOTS = 128,
    parameter int PW    = 15
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [PW-1:0]                value,
    output logic                         done,
    output logic [$clog2(SLOTS)-1:0]     slot
);
    localparam int SW = $clog2(SLOTS);
    localparam int SH = PW + SW;
    localparam int MW = PW + 1;
    localparam int XW = 2 * PW + 1;
    // exact quotient for every PW-bit value: floor(v * MAGIC / 2^SH)
    localparam logic [MW-1:0] MAGIC = MW'((64'd1 << SH) / 64'(SLOTS) + 64'd1);

    logic [PW-1:0] val_reg;
    logic [PW-1:0] q_reg;
    logic [PW-1:0] rem_reg;
    logic          p1_reg;
    logic          p2_reg;
    logic          done_reg;
    logic [XW-1:0] prod;
    logic [PW-1:0] q_w;
    logic [PW-1:0] back;

    assign prod = XW'(MAGIC) * XW'(val_reg);
    assign q_w  = PW'(prod >> SH);
    assign back = q_reg * PW'(SLOTS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg   <= 1'b0;
            p2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            p1_reg   <= start;
            p2_reg   <= p1_reg;
            done_reg <= p2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            val_reg <= value;
        if (p1_reg)
            q_reg <= q_w;
        if (p2_reg)
            rem_reg <= val_reg - back;
    end

    assign done = done_reg;
    assign slot = rem_reg[SW-1:0];
endmodule

// ===== rtl/core/process_id_table_engine_unit.sv =====
// ---------------------------------------------------------------------------
// process_id_table_engine_unit
// Process-id table: allocate, unallocate, detach, exit, join and query.
// ---------------------------------------------------------------------------
// One request is worked at a time, and every request gives one response.
// All slot state sits in a single RAM with a registered read; each visit of
// an entry is a read state, then an evaluate-and-write-back state. A lookup
// request (unallocate, detach, exit, join, query) first passes the
// reciprocal pid-to-slot reduction, then visits its slot. Allocate visits
// candidates in turn up to and including the free slot (about SLOTS at
// most while the live count is below SLOTS). Allocate rejected at once and
// unknown commands go straight to the response. Exit with detach_children
// then walks every slot and checks the caller's own slot again. After reset
// a clearing pass writes every slot before the first request is taken. A
// new request may be accepted while the previous response still waits.
// ---------------------------------------------------------------------------
module process_id_table_engine_unit #(
    parameter int SLOTS    = 128,
    parameter int PID_LOW  = 2,
    parameter int PID_HIGH = 32767
) (
    input  logic         clk,
    input  logic         rst_n,
    pit_stream_if.sink   cmd,
    pit_stream_if.source rsp
);
    import pit_pkg::*;

    localparam int PW        = (PID_HIGH > 32767) ? 16 : 15;
    localparam int SW        = $clog2(SLOTS);
    localparam int LW        = $clog2(SLOTS + 1);
    localparam int SPAN      = PID_HIGH - PID_LOW + 1;
    localparam int CW        = $clog2(SPAN);
    localparam int BOOT_SLOT = 1 % SLOTS;
    localparam int LOW_SLOT  = PID_LOW % SLOTS;

    typedef struct packed {
        logic [PW-1:0] pid;
        logic [PW-1:0] parent;
        pit_flags_t    flags;
        logic [31:0]   status;
    } entry_t;

    typedef enum logic [11:0] {
        ST_CLEAR   = 12'b0000_0000_0001,
        ST_IDLE    = 12'b0000_0000_0010,
        ST_MOD     = 12'b0000_0000_0100,
        ST_READ    = 12'b0000_0000_1000,
        ST_EVAL    = 12'b0000_0001_0000,
        ST_SCAN_RD = 12'b0000_0010_0000,
        ST_SCAN_EV = 12'b0000_0100_0000,
        ST_WALK_RD = 12'b0000_1000_0000,
        ST_WALK_EV = 12'b0001_0000_0000,
        ST_FIN_RD  = 12'b0010_0000_0000,
        ST_FIN_EV  = 12'b0100_0000_0000,
        ST_DONE    = 12'b1000_0000_0000
    } state_t;

    // table RAM
    entry_t        mem [SLOTS];
    entry_t        rd_data_reg;
    logic          mem_we;
    logic [SW-1:0] mem_waddr;
    logic [SW-1:0] mem_raddr;
    entry_t        mem_wdata;

    state_t        state_reg, state_next;
    pit_req_t      req_reg, req_next;
    logic [SW-1:0] slot_reg, slot_next;
    logic [PW-1:0] cand_reg, cand_next;
    logic [SW-1:0] cslot_reg, cslot_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [SW-1:0] walk_reg, walk_next;
    logic [PW-1:0] nxt_cand_reg, nxt_cand_next;
    logic [SW-1:0] nxt_slot_reg, nxt_slot_next;
    logic [LW-1:0] live_reg, live_next;
    pit_rsp_t      res_reg, res_next;
    pit_rsp_t      out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          mod_start;
    logic [PW-1:0] mod_value;
    logic          mod_done;
    logic [SW-1:0] mod_slot;

    entry_t        e;
    entry_t        upd;
    logic [PW-1:0] tgt_w, clr_w;
    logic          tgt_found, clr_found, tgt_in_range;
    logic [LW-1:0] live_dec;
    logic          accept;
    logic [PW-1:0] cand_adv;
    logic [SW-1:0] cslot_adv;

    pit_mod_unit #(
        .SLOTS (SLOTS),
        .PW    (PW)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (mod_value),
        .done  (mod_done),
        .slot  (mod_slot)
    );

    assign e      = rd_data_reg;
    assign tgt_w  = PW'(req_reg.subject_pid);
    assign clr_w  = PW'(req_reg.caller_pid);
    assign tgt_found = (req_reg.subject_pid != '0) && e.flags.valid && (e.pid == tgt_w);
    assign clr_found = (req_reg.caller_pid != '0) && e.flags.valid && (e.pid == clr_w);
    assign tgt_in_range = (32'(req_reg.subject_pid) >= 32'(PID_LOW))
                       && (32'(req_reg.subject_pid) <= 32'(PID_HIGH));
    assign live_dec = (live_reg != '0) ? live_reg - 1'b1 : live_reg;

    // advance the scan candidate together with its slot
    assign cand_adv  = (32'(cand_reg) >= 32'(PID_HIGH)) ? PW'(PID_LOW) : cand_reg + 1'b1;
    assign cslot_adv = (32'(cand_reg) >= 32'(PID_HIGH)) ? SW'(LOW_SLOT) :
                       (32'(cslot_reg) == 32'(SLOTS - 1)) ? '0 : cslot_reg + 1'b1;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign mod_value = (cmd.data.command == CMD_EXIT) ? PW'(cmd.data.caller_pid)
                                                      : PW'(cmd.data.subject_pid);

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        slot_next      = slot_reg;
        cand_next      = cand_reg;
        cslot_next     = cslot_reg;
        cnt_next       = cnt_reg;
        walk_next      = walk_reg;
        nxt_cand_next  = nxt_cand_reg;
        nxt_slot_next  = nxt_slot_reg;
        live_next      = live_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = slot_reg;
        mem_wdata      = '0;
        mem_raddr      = slot_reg;
        mod_start      = 1'b0;
        upd            = e;

        // drop the response once taken
        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = walk_reg;
                if (32'(walk_reg) == BOOT_SLOT)
                begin
                    mem_wdata.pid         = PW'(1);
                    mem_wdata.flags.valid = 1'b1;
                    mem_wdata.status      = BOOT_STATUS;
                end
                if (32'(walk_reg) == SLOTS - 1)
                    state_next = ST_IDLE;
                else
                    walk_next = walk_reg + 1'b1;
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    req_next = cmd.data;
                    res_next = '0;
                    unique case (cmd.data.command)
                        CMD_ALLOC:
                        begin
                            if (cmd.data.caller_pid == '0)
                            begin
                                res_next.result_code = RC_INVALID;
                                state_next = ST_DONE;
                            end
                            else if (32'(live_reg) >= SLOTS)
                            begin
                                res_next.result_code = RC_FULL;
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                cand_next  = nxt_cand_reg;
                                cslot_next = nxt_slot_reg;
                                cnt_next   = '0;
                                state_next = ST_SCAN_RD;
                            end
                        end
                        CMD_UNALOC, CMD_DETACH, CMD_EXIT, CMD_JOIN, CMD_QUERY:
                        begin
                            mod_start  = 1'b1;
                            state_next = ST_MOD;
                        end
                        default:
                        begin
                            res_next.result_code = RC_INVALID;
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_MOD:
            begin
                if (mod_done)
                begin
                    slot_next  = mod_slot;
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                mem_raddr  = slot_reg;
                state_next = ST_EVAL;
            end

            ST_EVAL:
            begin
                state_next = ST_DONE;
                unique case (req_reg.command)
                    CMD_UNALOC:
                    begin
                        if (!tgt_in_range)
                            res_next.result_code = RC_INVALID;
                        else if (!tgt_found)
                            res_next.result_code = RC_NOPID;
                        else if (e.flags.exited || e.parent != clr_w)
                            res_next.result_code = RC_INVALID;
                        else
                        begin
                            mem_we    = 1'b1;
                            live_next = live_dec;
                        end
                    end
                    CMD_DETACH:
                    begin
                        if (32'(req_reg.subject_pid) < PID_LOW || req_reg.subject_pid < 2)
                            res_next.result_code = RC_INVALID;
                        else if (!tgt_found)
                            res_next.result_code = RC_NOPID;
                        else if (e.parent == '0 || e.parent != clr_w)
                            res_next.result_code = RC_INVALID;
                        else
                        begin
                            mem_we = 1'b1;
                            if (e.flags.exited)
                                live_next = live_dec;
                            else
                            begin
                                upd.parent         = '0;
                                upd.flags.detached = 1'b1;
                                mem_wdata          = upd;
                            end
                        end
                    end
                    CMD_EXIT:
                    begin
                        if (!clr_found)
                            res_next.result_code = RC_NOPID;
                        else
                        begin
                            mem_we           = 1'b1;
                            upd.flags.exited = 1'b1;
                            upd.status       = req_reg.exit_code;
                            if (req_reg.detach_children)
                            begin
                                mem_wdata  = upd;
                                walk_next  = '0;
                                state_next = ST_WALK_RD;
                            end
                            else if (e.flags.detached)
                                live_next = live_dec;
                            else
                                mem_wdata = upd;
                        end
                    end
                    CMD_JOIN:
                    begin
                        if (req_reg.subject_pid < 2 || !tgt_in_range)
                            res_next.result_code = RC_INVALID;
                        else if (!tgt_found)
                            res_next.result_code = RC_NOPID;
                        else if (e.parent == '0)
                            res_next.result_code = RC_INVALID;
                        else if (req_reg.subject_pid == req_reg.caller_pid)
                            res_next.result_code = RC_DEADLOCK;
                        else if (!e.flags.exited)
                        begin
                            if (!req_reg.no_hang)
                                res_next.result_code = RC_WAIT;
                        end
                        else
                        begin
                            res_next.result_pid      = req_reg.subject_pid;
                            res_next.exit_status_out = e.status;
                        end
                    end
                    CMD_QUERY:
                    begin
                        if (!tgt_found)
                            res_next.result_code = RC_NOPID;
                        else
                            res_next.parent_match = (e.parent == clr_w);
                    end
                    default:
                        res_next.result_code = RC_INVALID;
                endcase
            end

            ST_SCAN_RD:
            begin
                mem_raddr  = cslot_reg;
                state_next = ST_SCAN_EV;
            end

            ST_SCAN_EV:
            begin
                if (!e.flags.valid)
                begin
                    mem_we                = 1'b1;
                    mem_waddr             = cslot_reg;
                    mem_wdata.pid         = cand_reg;
                    mem_wdata.parent      = clr_w;
                    mem_wdata.flags.valid = 1'b1;
                    mem_wdata.status      = BOOT_STATUS;
                    live_next             = live_reg + 1'b1;
                    nxt_cand_next         = cand_adv;
                    nxt_slot_next         = cslot_adv;
                    res_next.result_pid   = PORT_PID_W'(cand_reg);
                    state_next            = ST_DONE;
                end
                else if (32'(cnt_reg) == SPAN - 1)
                begin
                    res_next.result_code = RC_FULL;
                    state_next           = ST_DONE;
                end
                else
                begin
                    cand_next  = cand_adv;
                    cslot_next = cslot_adv;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end

            ST_WALK_RD:
            begin
                mem_raddr  = walk_reg;
                state_next = ST_WALK_EV;
            end

            ST_WALK_EV:
            begin
                // detach each child of the exiting caller, free exited ones
                mem_waddr = walk_reg;
                if (e.flags.valid && e.parent == clr_w)
                begin
                    mem_we = 1'b1;
                    if (e.flags.exited)
                        live_next = live_dec;
                    else
                    begin
                        upd.parent         = '0;
                        upd.flags.detached = 1'b1;
                        mem_wdata          = upd;
                    end
                end
                if (32'(walk_reg) == SLOTS - 1)
                    state_next = ST_FIN_RD;
                else
                begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = ST_WALK_RD;
                end
            end

            ST_FIN_RD:
            begin
                mem_raddr  = slot_reg;
                state_next = ST_FIN_EV;
            end

            ST_FIN_EV:
            begin
                if (e.flags.valid && e.pid == clr_w && e.flags.detached)
                begin
                    mem_we    = 1'b1;
                    live_next = live_dec;
                end
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                // hold until the response register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            walk_reg      <= '0;
            nxt_cand_reg  <= PW'(PID_LOW);
            nxt_slot_reg  <= SW'(LOW_SLOT);
            live_reg      <= LW'(1);
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_reg      <= walk_next;
            nxt_cand_reg  <= nxt_cand_next;
            nxt_slot_reg  <= nxt_slot_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        slot_reg  <= slot_next;
        cand_reg  <= cand_next;
        cslot_reg <= cslot_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

`include "process_id_table_engine_unit_assert.svh"

    `PIT_ASSERT_IMPL(a_live_bound, clk, rst_n, 1'b1, 32'(live_reg) <= SLOTS)
    `PIT_ASSERT_IMPL(a_rsp_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == ST_DONE)
    `PIT_ASSERT_IMPL(a_full_no_scan, clk, rst_n, state_reg == ST_SCAN_RD, 32'(live_reg) < SLOTS)
    `PIT_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, accept, state_reg != ST_IDLE)

endmodule

// ===== test/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the process-id table engine: drives request
// streams through the command channel, predicts every response with an
// independent table model and compares them field by field.
// ---------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pit_pkg::*;

    localparam int SLOTS    = 128;
    localparam int PID_LOW  = 2;
    localparam int PID_HIGH = 32767;
    localparam int PID_SPAN = PID_HIGH - PID_LOW + 1;
    localparam int BOOT_PID = 1;
    localparam int NUM_RANDOM  = 1630;
    localparam int IDLE_LIMIT  = 20000;
    localparam int LONG_HOLD   = 300;

    localparam logic [2:0] CMD_BAD6 = 3'd6;
    localparam logic [2:0] CMD_BAD7 = 3'd7;

    // Shadow of the pid table. One copy follows accepted requests, a second
    // one runs ahead at generation time so stimulus can aim at live pids.
    typedef struct {
        logic [14:0] pid    [SLOTS];
        logic [14:0] parent [SLOTS];
        pit_flags_t  flags  [SLOTS];
        logic [31:0] status [SLOTS];
        int          next_cand;
        int          live;
    } pid_table_t;

    logic clk;
    logic rst_n;

    pit_stream_if #(.payload_t(pit_req_t)) cmd_ch ();
    pit_stream_if #(.payload_t(pit_rsp_t)) rsp_ch ();

    process_id_table_engine_unit #(
        .SLOTS    (SLOTS),
        .PID_LOW  (PID_LOW),
        .PID_HIGH (PID_HIGH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    pid_table_t live_tbl;   // follows accepted requests
    pid_table_t gen_tbl;    // follows generated requests

    pit_req_t pending_reqs[$];
    pit_rsp_t expected_rsps[$];

    int error_count;
    int req_count;
    int rsp_count;
    int idle_cycles;
    int cmd_seen[8];
    int rc_seen[8];

    // -----------------------------------------------------------------------
    // Table model
    // -----------------------------------------------------------------------
    function automatic void table_reset(ref pid_table_t t);
        int i;
        for (i = 0; i < SLOTS; i++)
        begin
            t.pid[i]    = '0;
            t.parent[i] = '0;
            t.flags[i]  = '0;
            t.status[i] = '0;
        end
        t.pid[BOOT_PID % SLOTS]          = 15'(BOOT_PID);
        t.flags[BOOT_PID % SLOTS].valid  = 1'b1;
        t.status[BOOT_PID % SLOTS]       = BOOT_STATUS;
        t.next_cand = PID_LOW;
        t.live      = 1;
    endfunction

    // Slot index holding pid, or -1 when the pid is not present.
    function automatic int slot_lookup(ref pid_table_t t, input int pid);
        int s;
        s = pid % SLOTS;
        if (pid == 0 || !t.flags[s].valid || t.pid[s] != 15'(pid))
            return -1;
        return s;
    endfunction

    function automatic void slot_free(ref pid_table_t t, input int s);
        t.pid[s]    = '0;
        t.parent[s] = '0;
        t.flags[s]  = '0;
        t.status[s] = '0;
        if (t.live > 0)
            t.live--;
    endfunction

    function automatic int pid_advance(input int pid);
        return (pid + 1 > PID_HIGH) ? PID_LOW : pid + 1;
    endfunction

    // Work out the response of one request and update the table.
    function automatic pit_rsp_t table_apply(ref pid_table_t t, input pit_req_t r);
        pit_rsp_t o;
        int tgt;
        int clr;
        int s;
        int i;
        int cand;
        bit found;
        o   = '0;
        tgt = int'(r.subject_pid);
        clr = int'(r.caller_pid);
        o.result_code = RC_OK;
        case (r.command)
            CMD_ALLOC:
            begin
                if (clr == 0)
                    o.result_code = RC_INVALID;
                else if (t.live >= SLOTS)
                    o.result_code = RC_FULL;
                else
                begin
                    cand  = t.next_cand;
                    found = 1'b0;
                    for (i = 0; i < PID_SPAN && !found; i++)
                    begin
                        if (!t.flags[cand % SLOTS].valid)
                            found = 1'b1;
                        else
                            cand = pid_advance(cand);
                    end
                    if (!found)
                        o.result_code = RC_FULL;
                    else
                    begin
                        s = cand % SLOTS;
                        t.pid[s]    = 15'(cand);
                        t.parent[s] = 15'(clr);
                        t.flags[s]  = '0;
                        t.flags[s].valid = 1'b1;
                        t.status[s] = BOOT_STATUS;
                        t.live++;
                        t.next_cand  = pid_advance(cand);
                        o.result_pid = 15'(cand);
                    end
                end
            end
            CMD_UNALOC:
            begin
                s = slot_lookup(t, tgt);
                if (tgt < PID_LOW || tgt > PID_HIGH)
                    o.result_code = RC_INVALID;
                else if (s < 0)
                    o.result_code = RC_NOPID;
                else if (t.flags[s].exited || t.parent[s] != 15'(clr))
                    o.result_code = RC_INVALID;
                else
                    slot_free(t, s);
            end
            CMD_DETACH:
            begin
                s = slot_lookup(t, tgt);
                if (tgt == 0 || tgt == BOOT_PID || tgt < PID_LOW)
                    o.result_code = RC_INVALID;
                else if (s < 0)
                    o.result_code = RC_NOPID;
                else if (t.parent[s] == '0 || t.parent[s] != 15'(clr))
                    o.result_code = RC_INVALID;
                else
                begin
                    t.parent[s] = '0;
                    t.flags[s].detached = 1'b1;
                    if (t.flags[s].exited)
                        slot_free(t, s);
                end
            end
            CMD_EXIT:
            begin
                s = slot_lookup(t, clr);
                if (s < 0)
                    o.result_code = RC_NOPID;
                else
                begin
                    t.flags[s].exited = 1'b1;
                    t.status[s] = r.exit_code;
                    if (r.detach_children)
                    begin
                        for (i = 0; i < SLOTS; i++)
                        begin
                            if (t.flags[i].valid && t.parent[i] == 15'(clr))
                            begin
                                t.parent[i] = '0;
                                t.flags[i].detached = 1'b1;
                                if (t.flags[i].exited)
                                    slot_free(t, i);
                            end
                        end
                    end
                    if (t.flags[s].valid && t.pid[s] == 15'(clr) && t.flags[s].detached)
                        slot_free(t, s);
                end
            end
            CMD_JOIN:
            begin
                s = slot_lookup(t, tgt);
                if (tgt == 0 || tgt == BOOT_PID || tgt < PID_LOW || tgt > PID_HIGH)
                    o.result_code = RC_INVALID;
                else if (s < 0)
                    o.result_code = RC_NOPID;
                else if (t.parent[s] == '0)
                    o.result_code = RC_INVALID;
                else if (tgt == clr)
                    o.result_code = RC_DEADLOCK;
                else if (!t.flags[s].exited)
                begin
                    if (!r.no_hang)
                        o.result_code = RC_WAIT;
                end
                else
                begin
                    o.result_pid      = 15'(tgt);
                    o.exit_status_out = t.status[s];
                end
            end
            CMD_QUERY:
            begin
                s = slot_lookup(t, tgt);
                if (s < 0)
                    o.result_code = RC_NOPID;
                else
                    o.parent_match = (t.parent[s] == 15'(clr));
            end
            default:
                o.result_code = RC_INVALID;
        endcase
        return o;
    endfunction

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    function automatic pit_req_t make_req(input logic [2:0] c, input int tgt,
                                          input int clr, input logic [31:0] code,
                                          input logic dk, input logic nh);
        pit_req_t r;
        r.command         = c;
        r.subject_pid     = 15'(tgt);
        r.caller_pid      = 15'(clr);
        r.exit_code       = code;
        r.detach_children = dk;
        r.no_hang         = nh;
        return r;
    endfunction

    // Queue a request and keep the look-ahead table in step with it.
    task automatic queue_req(input pit_req_t r);
        pit_rsp_t unused;
        unused = table_apply(gen_tbl, r);
        pending_reqs.push_back(r);
    endtask

    // Pick a live slot at random; -1 when none was hit.
    function automatic int pick_live_slot(ref pid_table_t t);
        int k;
        int s;
        for (k = 0; k < 16; k++)
        begin
            s = $urandom_range(0, SLOTS - 1);
            if (t.flags[s].valid)
                return s;
        end
        return -1;
    endfunction

    task automatic queue_random_req();
        pit_req_t r;
        int s;
        int sel;
        int tgt;
        int clr;
        r = make_req(CMD_ALLOC, 0, 0, $urandom, 1'($urandom), 1'($urandom));
        s   = pick_live_slot(gen_tbl);
        tgt = (s < 0) ? $urandom_range(0, PID_HIGH) : int'(gen_tbl.pid[s]);
        clr = (s < 0) ? $urandom_range(0, PID_HIGH) : int'(gen_tbl.parent[s]);
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            r.command = CMD_ALLOC;
            clr = ($urandom_range(0, 19) == 0) ? 0 : tgt;
        end
        else if (sel < 40)
            r.command = CMD_UNALOC;
        else if (sel < 50)
            r.command = CMD_DETACH;
        else if (sel < 65)
        begin
            r.command = CMD_EXIT;
            clr = tgt;
        end
        else if (sel < 85)
        begin
            r.command = CMD_JOIN;
            if ($urandom_range(0, 9) == 0)
                clr = tgt;
        end
        else if (sel < 95)
        begin
            r.command = CMD_QUERY;
            if ($urandom_range(0, 3) == 0)
                clr = $urandom_range(0, PID_HIGH);
        end
        else
            r.command = ($urandom_range(0, 1) != 0) ? CMD_BAD7 : CMD_BAD6;
        // Some noise on the pid fields so that every bit toggles.
        if ($urandom_range(0, 9) == 0)
            tgt = $urandom_range(0, PID_HIGH);
        if ($urandom_range(0, 9) == 0)
            clr = $urandom_range(0, PID_HIGH);
        r.subject_pid = 15'(tgt);
        r.caller_pid  = 15'(clr);
        queue_req(r);
    endtask

    task automatic queue_directed();
        // Boot process and out-of-range pids.
        queue_req(make_req(CMD_QUERY,  BOOT_PID, 0, '0, 0, 0));
        queue_req(make_req(CMD_QUERY,  0, 0, '0, 0, 0));
        queue_req(make_req(CMD_ALLOC,  0, 0, '0, 0, 0));
        queue_req(make_req(CMD_ALLOC,  0, BOOT_PID, '0, 0, 0));
        queue_req(make_req(CMD_ALLOC,  0, PID_HIGH, '0, 0, 0));
        queue_req(make_req(CMD_JOIN,   2, BOOT_PID, '0, 0, 0));
        queue_req(make_req(CMD_JOIN,   2, BOOT_PID, '0, 0, 1));
        queue_req(make_req(CMD_JOIN,   2, 2, '0, 0, 0));
        queue_req(make_req(CMD_JOIN,   BOOT_PID, 0, '0, 0, 0));
        queue_req(make_req(CMD_JOIN,   0, 0, '0, 0, 0));
        queue_req(make_req(CMD_JOIN,   PID_HIGH, 1, '0, 0, 0));
        queue_req(make_req(CMD_DETACH, BOOT_PID, 0, '0, 0, 0));
        queue_req(make_req(CMD_DETACH, 0, 0, '0, 0, 0));
        queue_req(make_req(CMD_UNALOC, PID_HIGH, 1, '0, 0, 0));
        queue_req(make_req(CMD_UNALOC, 0, 1, '0, 0, 0));
        // Child exits with the extreme codes, parent joins, then detaches.
        queue_req(make_req(CMD_EXIT,   0, 2, 32'h8000_0000, 0, 0));
        queue_req(make_req(CMD_JOIN,   2, BOOT_PID, '0, 0, 0));
        queue_req(make_req(CMD_EXIT,   0, 3, 32'h7fff_ffff, 0, 0));
        queue_req(make_req(CMD_EXIT,   0, 3, 32'hffff_ffff, 0, 0));
        queue_req(make_req(CMD_JOIN,   3, BOOT_PID, '0, 0, 0));
        queue_req(make_req(CMD_DETACH, 2, BOOT_PID, '0, 0, 0));
        queue_req(make_req(CMD_EXIT,   0, 9999, '0, 0, 0));
        queue_req(make_req(CMD_EXIT,   0, BOOT_PID, 32'h1234_5678, 1, 0));
        queue_req(make_req(CMD_BAD6,   PID_HIGH, PID_HIGH, '1, 1, 1));
        queue_req(make_req(CMD_BAD7,   0, 0, '0, 0, 0));
    endtask

    // -----------------------------------------------------------------------
    // Clock
    // -----------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // -----------------------------------------------------------------------
    // Sender: bursts of random length separated by random gaps. Hold the
    // current request while the engine is not ready.
    // -----------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.data  <= '0;
            burst_left   = 0;
            gap_left     = 0;
        end
        else if (cmd_ch.valid && !cmd_ch.ready)
        begin
            // hold
        end
        else if (gap_left > 0)
        begin
            cmd_ch.valid <= 1'b0;
            gap_left--;
        end
        else if (pending_reqs.size() > 0)
        begin
            cmd_ch.data  <= pending_reqs.pop_front();
            cmd_ch.valid <= 1'b1;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
        else
            cmd_ch.valid <= 1'b0;
    end

    // -----------------------------------------------------------------------
    // Receiver: stall on a mode that is redrawn at random periodically, and
    // once hold ready low for a long stretch so the engine backs up.
    // -----------------------------------------------------------------------
    int rx_cycle;
    int rx_mode;
    int hold_left;
    bit hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            rx_cycle  = 0;
            rx_mode   = 0;
            hold_left = 0;
            hold_done = 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 400 == 0)
                rx_mode = $urandom_range(0, 2);
            if (!hold_done && req_count >= 600)
            begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (rx_mode == 0)
                rsp_ch.ready <= 1'b1;
            else if (rx_mode == 1)
                rsp_ch.ready <= (rx_cycle % 5) != 2;
            else
                rsp_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // -----------------------------------------------------------------------
    // Monitor: predict on each accepted request, check each accepted
    // response against the oldest expectation.
    // -----------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH response %0d %s: got 0x%0h expected 0x%0h",
                 rsp_count, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        pit_rsp_t want;
        pit_rsp_t got;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                want = table_apply(live_tbl, cmd_ch.data);
                expected_rsps.push_back(want);
                cmd_seen[cmd_ch.data.command]++;
                req_count++;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.data;
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected response", '0, '0);
                else
                begin
                    want = expected_rsps.pop_front();
                    rc_seen[want.result_code]++;
                    if (got.result_code !== want.result_code)
                        report_mismatch("result_code", 32'(got.result_code),
                                        32'(want.result_code));
                    if (got.result_pid !== want.result_pid)
                        report_mismatch("result_pid", 32'(got.result_pid),
                                        32'(want.result_pid));
                    if (got.exit_status_out !== want.exit_status_out)
                        report_mismatch("exit_status_out", got.exit_status_out,
                                        want.exit_status_out);
                    if (got.parent_match !== want.parent_match)
                        report_mismatch("parent_match", 32'(got.parent_match),
                                        32'(want.parent_match));
                end
                rsp_count++;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Watchdog: advance a counter on cycles where no handshake happens.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: %0d requests outstanding", expected_rsps.size());
            $display("process_id_table_engine_unit verification failed");
            $finish;
        end
    end

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        int n;
        int k;
        error_count = 0;
        req_count   = 0;
        rsp_count   = 0;
        idle_cycles = 0;
        for (k = 0; k < 8; k++)
        begin
            cmd_seen[k] = 0;
            rc_seen[k]  = 0;
        end
        rst_n = 1'b0;
        table_reset(live_tbl);
        table_reset(gen_tbl);
        queue_directed();
        for (n = 0; n < NUM_RANDOM; n++)
            queue_random_req();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: all requests sent, all responses back, then a short tail.
        while (pending_reqs.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        while (expected_rsps.size() != 0)
            @(posedge clk);
        repeat (2 * SLOTS + 64) @(posedge clk);

        $display("ran %0d requests (alloc %0d, unalloc %0d, detach %0d, exit %0d, join %0d, "
                 , req_count, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3], cmd_seen[4]);
        $display("  query %0d, illegal %0d); codes ok %0d full %0d wait %0d deadlock %0d",
                 cmd_seen[5], cmd_seen[6] + cmd_seen[7], rc_seen[0], rc_seen[4],
                 rc_seen[5], rc_seen[3]);
        if (error_count == 0)
            $display("process_id_table_engine_unit verification clean");
        else
            $display("process_id_table_engine_unit verification failed");
        $finish;
    end

endmodule
